@@ design/hba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hba_pkg
// Shared sizes, codes and control/status types of the heap block allocator.
// ----------------------------------------------------------------------------
package hba_pkg;

    localparam int MAX_BLOCKS = 32;
    localparam int SIZE_BITS  = 24;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int POS_W      = SIZE_BITS + CNT_W + 1;
    localparam int HDR_W      = 7;
    localparam int POL_W      = 2;
    localparam int STAT_W     = 3;
    localparam int ADDR_W     = 4;

    localparam logic [HDR_W-1:0]     HDR_RESET   = HDR_W'(24);
    localparam logic [SIZE_BITS-1:0] LIMIT_RESET = {SIZE_BITS{1'b1}};

    // register indexes (word address)
    localparam logic [1:0] REG_FIT   = 2'd0;
    localparam logic [1:0] REG_HDR   = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;

    // fit policies
    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;
    localparam logic [POL_W-1:0] POL_NEXT  = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_ALLOC   = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FREED   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NULL    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOSPACE = 3'd3;
    localparam logic [STAT_W-1:0] STAT_UNKNOWN = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_ALLOC,
        ST_POS,
        ST_FIND,
        ST_MERGE_INIT,
        ST_MERGE,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN_INIT,
        OP_SCAN,
        OP_ALLOC,
        OP_POS,
        OP_FIND_INIT,
        OP_FIND,
        OP_FREE_HIT,
        OP_MERGE_INIT,
        OP_MERGE,
        OP_RES_NULL,
        OP_RES_NOSPACE,
        OP_RES_UNKNOWN,
        OP_EMIT
    } t_op;

    typedef struct packed {
        logic [POL_W-1:0]     fit_policy;
        logic [HDR_W-1:0]     header_bytes;
        logic [SIZE_BITS-1:0] heap_limit;
    } t_cfg;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic mode;
        logic s_zero;
        logic s_big;
        logic tgt_zero;
        logic iter_done;
        logic alloc_ok;
        logic pos_done;
        logic find_hit;
        logic merge_done;
        logic out_free;
    } t_dp_status;

endpackage

@@ design/heap_block_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_block_allocator
// Heap allocator over an address-ordered block table: first/best/worst/next
// fit, split on allocate, growth at the top, merge of free runs on release.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (low bit up)                 | tuser
//  s_axis   | in        | request_size[23:0], free_offset    | mode
//  m_axis   | out       | data_offset[23:0], granted_size    | status
//  apb      | in/out    | fit_policy @0, header_bytes @4, heap_limit @8
//
//  One transaction at a time. Allocate: accept, check, fit search,
//  split/grow, offset walk, result load. Free: accept, check, lookup,
//  merge set-up and pass on a hit, result load.
//  A waiting result is held in the output register while a new request is
//  taken. Reset clears the table flags and counts at once; no clearing pass.
// ----------------------------------------------------------------------------
module heap_block_allocator
    import hba_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [47:0]       s_axis_tdata,   // request_size, free_offset
    input  logic              s_axis_tuser,   // mode
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [47:0]       m_axis_tdata,   // data_offset, granted_size
    output logic [2:0]        m_axis_tuser,   // status
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg       w_cfg;
    t_dp_cmd    w_cmd;
    t_dp_status w_st;

    hba_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    hba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    hba_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_cmd          (w_cmd),
        .o_st           (w_st),
        .i_mode         (s_axis_tuser),
        .i_request_size (s_axis_tdata[23:0]),
        .i_free_offset  (s_axis_tdata[47:24]),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_data_offset  (m_axis_tdata[23:0]),
        .o_granted_size (m_axis_tdata[47:24]),
        .o_status       (m_axis_tuser)
    );

endmodule

@@ design/hba_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hba_regs
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module hba_regs
    import hba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output t_cfg                 o_cfg
);

    logic [POL_W-1:0]     r_policy;
    logic [HDR_W-1:0]     r_hdr;
    logic [SIZE_BITS-1:0] r_limit;
    logic                 w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_FIRST;
            r_hdr    <= HDR_RESET;
            r_limit  <= LIMIT_RESET;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_FIT:   r_policy <= pwdata[POL_W-1:0];
                REG_HDR:   r_hdr    <= pwdata[HDR_W-1:0];
                REG_LIMIT: r_limit  <= pwdata[SIZE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_FIT:   prdata = 32'(r_policy);
            REG_HDR:   prdata = 32'(r_hdr);
            REG_LIMIT: prdata = 32'(r_limit);
            default:   prdata = 32'd0;
        endcase
    end

    assign o_cfg.fit_policy   = r_policy;
    assign o_cfg.header_bytes = r_hdr;
    assign o_cfg.heap_limit   = r_limit;

endmodule

@@ design/hba_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hba_ctrl
// Sequencer: steps the datapath through search, split/grow, offset walk,
// lookup and merge passes for one transaction at a time.
// ----------------------------------------------------------------------------
module hba_ctrl
    import hba_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_st,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (!i_st.mode) begin
                    if (i_st.s_zero || i_st.s_big) n_state = ST_DONE;
                    else n_state = ST_SCAN;
                end else begin
                    if (i_st.tgt_zero) n_state = ST_DONE;
                    else n_state = ST_FIND;
                end
            end
            ST_SCAN: begin
                if (i_st.iter_done) n_state = ST_ALLOC;
            end
            ST_ALLOC: begin
                n_state = i_st.alloc_ok ? ST_POS : ST_DONE;
            end
            ST_POS: begin
                if (i_st.pos_done) n_state = ST_DONE;
            end
            ST_FIND: begin
                if (i_st.iter_done) n_state = ST_DONE;
                else if (i_st.find_hit) n_state = ST_MERGE_INIT;
            end
            ST_MERGE_INIT: n_state = ST_MERGE;
            ST_MERGE: begin
                if (i_st.merge_done) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_st.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.op   = OP_NONE;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = OP_LOAD;
            end
            ST_CHECK: begin
                if (!i_st.mode) begin
                    if (i_st.s_zero) o_cmd.op = OP_RES_NULL;
                    else if (i_st.s_big) o_cmd.op = OP_RES_NOSPACE;
                    else o_cmd.op = OP_SCAN_INIT;
                end else begin
                    o_cmd.op = i_st.tgt_zero ? OP_RES_NULL : OP_FIND_INIT;
                end
            end
            ST_SCAN: begin
                if (!i_st.iter_done) o_cmd.op = OP_SCAN;
            end
            ST_ALLOC: o_cmd.op = OP_ALLOC;
            ST_POS:   o_cmd.op = OP_POS;
            ST_FIND: begin
                if (i_st.iter_done) o_cmd.op = OP_RES_UNKNOWN;
                else if (i_st.find_hit) o_cmd.op = OP_FREE_HIT;
                else o_cmd.op = OP_FIND;
            end
            ST_MERGE_INIT: o_cmd.op = OP_MERGE_INIT;
            ST_MERGE: begin
                if (!i_st.merge_done) o_cmd.op = OP_MERGE;
            end
            ST_DONE: begin
                if (i_st.out_free) o_cmd.op = OP_EMIT;
            end
            default: ;
        endcase
    end

endmodule

@@ design/hba_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hba_datapath
// Block table, heap state, scan/walk counters and the result register.
// ----------------------------------------------------------------------------
module hba_datapath
    import hba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_st,
    input  logic                 i_mode,
    input  logic [SIZE_BITS-1:0] i_request_size,
    input  logic [SIZE_BITS-1:0] i_free_offset,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [SIZE_BITS-1:0] o_data_offset,
    output logic [SIZE_BITS-1:0] o_granted_size,
    output logic [STAT_W-1:0]    o_status
);

    localparam logic [CNT_W-1:0]     CNT_MAX  = CNT_W'(MAX_BLOCKS);
    localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};

    // block table
    logic [SIZE_BITS-1:0] r_size [MAX_BLOCKS];
    logic [SIZE_BITS-1:0] n_size [MAX_BLOCKS];
    logic                 r_free [MAX_BLOCKS];
    logic                 n_free [MAX_BLOCKS];

    // heap state
    logic [CNT_W-1:0]     r_count;
    logic [SIZE_BITS-1:0] r_top;
    logic [CNT_W-1:0]     r_ri;
    logic                 r_rv;

    // request and working registers
    logic                 r_mode;
    logic [SIZE_BITS-1:0] r_req;
    logic [SIZE_BITS-1:0] r_target;
    logic [IDX_W-1:0]     r_idx;
    logic [CNT_W-1:0]     r_iter;
    logic [IDX_W-1:0]     r_pick;
    logic                 r_has_pick;
    logic [SIZE_BITS-1:0] r_pick_size;
    logic [IDX_W-1:0]     r_tgt;
    logic [POS_W-1:0]     r_pos;
    logic [IDX_W-1:0]     r_m;
    logic [SIZE_BITS-1:0] r_acc;
    logic                 r_acc_free;
    logic [SIZE_BITS-1:0] r_res_off;
    logic [SIZE_BITS-1:0] r_res_size;
    logic [STAT_W-1:0]    r_res_status;

    // output register
    logic                 r_out_valid;
    logic [SIZE_BITS-1:0] r_out_off;
    logic [SIZE_BITS-1:0] r_out_size;
    logic [STAT_W-1:0]    r_out_status;

    logic [HDR_W-1:0]     w_hdr;
    logic [SIZE_BITS-1:0] w_s;
    logic [SIZE_BITS-1:0] w_rd_size;
    logic                 w_rd_free;
    logic [SIZE_BITS-1:0] w_rem;
    logic                 w_split;
    logic [SIZE_BITS+1:0] w_grow_sum;
    logic                 w_grow_ok;
    logic [IDX_W-1:0]     w_pick_nx;
    logic                 w_fit;
    logic                 w_upd;
    logic [POS_W-1:0]     w_pos_step;
    logic [POS_W-1:0]     w_pos_hdr;
    logic [SIZE_BITS+1:0] w_merge_sum;
    logic [SIZE_BITS-1:0] w_merge_sat;
    logic                 w_absorb;
    logic [CNT_W-1:0]     w_ri1;
    logic                 w_rv1;

    assign w_hdr     = (i_cfg.header_bytes == '0) ? HDR_W'(1) : i_cfg.header_bytes;
    // round up to a multiple of 4; valid only when neither zero nor oversized
    assign w_s       = ((r_req - SIZE_BITS'(1)) | SIZE_BITS'(3)) + SIZE_BITS'(1);
    assign w_rd_size = r_size[r_idx];
    assign w_rd_free = r_free[r_idx];

    assign w_rem      = r_pick_size - w_s;
    assign w_split    = (r_count < CNT_MAX) && (w_rem > SIZE_BITS'(w_hdr));
    assign w_grow_sum = {2'b00, r_top} + (SIZE_BITS+2)'(w_hdr) + {2'b00, w_s};
    assign w_grow_ok  = (r_count < CNT_MAX) && (w_grow_sum <= {2'b00, i_cfg.heap_limit});
    assign w_pick_nx  = r_pick + IDX_W'(1);

    assign w_fit = w_rd_free && (w_rd_size >= w_s);
    assign w_upd = w_fit && (!r_has_pick ||
                   (i_cfg.fit_policy == POL_BEST  && w_rd_size < r_pick_size) ||
                   (i_cfg.fit_policy == POL_WORST && w_rd_size > r_pick_size));

    assign w_pos_step = r_pos + POS_W'(w_hdr) + POS_W'(w_rd_size);
    assign w_pos_hdr  = r_pos + POS_W'(w_hdr);

    assign w_merge_sum = {2'b00, r_acc} + {2'b00, w_rd_size} + (SIZE_BITS+2)'(w_hdr);
    assign w_merge_sat = (w_merge_sum > {2'b00, SIZE_MAX}) ? SIZE_MAX
                                                          : w_merge_sum[SIZE_BITS-1:0];
    assign w_absorb    = r_acc_free && w_rd_free;

    // resume pointer after a next-fit search
    always_comb begin
        w_ri1 = r_ri;
        w_rv1 = r_rv;
        if (i_cfg.fit_policy == POL_NEXT) begin
            w_rv1 = r_has_pick;
            w_ri1 = r_has_pick ? CNT_W'(r_pick) : '0;
        end
    end

    // status to the sequencer
    assign o_st.mode       = r_mode;
    assign o_st.s_zero     = (r_req == '0);
    assign o_st.s_big      = (r_req > (SIZE_MAX - SIZE_BITS'(3)));
    assign o_st.tgt_zero   = (r_target == '0);
    assign o_st.iter_done  = (r_iter == r_count);
    assign o_st.alloc_ok   = r_has_pick || w_grow_ok;
    assign o_st.pos_done   = (r_idx == r_tgt);
    assign o_st.find_hit   = (r_iter != r_count) && (w_pos_hdr == POS_W'(r_target));
    assign o_st.merge_done = ((CNT_W'(r_m) + CNT_W'(1)) >= r_count);
    assign o_st.out_free   = !r_out_valid || i_ready;

    // table updates: shifts run over every entry in parallel
    always_comb begin
        for (int k = 0; k < MAX_BLOCKS; k++) begin
            n_size[k] = r_size[k];
            n_free[k] = r_free[k];
        end
        case (i_cmd.op)
            OP_ALLOC: begin
                if (r_has_pick) begin
                    if (w_split) begin
                        for (int k = 1; k < MAX_BLOCKS; k++) begin
                            if (IDX_W'(k) > w_pick_nx) begin
                                n_size[k] = r_size[k-1];
                                n_free[k] = r_free[k-1];
                            end
                        end
                        n_size[w_pick_nx] = w_rem - SIZE_BITS'(w_hdr);
                        n_free[w_pick_nx] = 1'b1;
                        n_size[r_pick]    = w_s;
                    end
                    n_free[r_pick] = 1'b0;
                end else if (w_grow_ok) begin
                    n_size[r_count[IDX_W-1:0]] = w_s;
                    n_free[r_count[IDX_W-1:0]] = 1'b0;
                end
            end
            OP_FREE_HIT: n_free[r_idx] = 1'b1;
            OP_MERGE: begin
                if (w_absorb) begin
                    for (int k = 0; k < MAX_BLOCKS - 1; k++) begin
                        if (IDX_W'(k) > r_m) begin
                            n_size[k] = r_size[k+1];
                            n_free[k] = r_free[k+1];
                        end
                    end
                    n_size[r_m] = w_merge_sat;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_BLOCKS; k++) begin
            r_size[k] <= n_size[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_BLOCKS; k++) begin
                r_free[k] <= 1'b0;
            end
        end else begin
            for (int k = 0; k < MAX_BLOCKS; k++) begin
                r_free[k] <= n_free[k];
            end
        end
    end

    // heap control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_top   <= '0;
            r_ri    <= '0;
            r_rv    <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_ALLOC: begin
                    // a split inserts an entry, so a pointer past the pick moves up
                    r_ri <= (r_has_pick && w_split && w_rv1 && (w_ri1 > CNT_W'(r_pick)))
                            ? w_ri1 + CNT_W'(1) : w_ri1;
                    r_rv <= w_rv1;
                    if (r_has_pick) begin
                        if (w_split) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end else if (w_grow_ok) begin
                        r_count <= r_count + CNT_W'(1);
                        r_top   <= w_grow_sum[SIZE_BITS-1:0];
                    end
                end
                OP_MERGE: begin
                    if (w_absorb) begin
                        r_count <= r_count - CNT_W'(1);
                        if (r_rv && (r_ri > CNT_W'(r_m))) r_ri <= r_ri - CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_mode   <= i_mode;
                r_req    <= i_request_size;
                r_target <= i_free_offset;
            end
            OP_SCAN_INIT: begin
                r_iter     <= '0;
                r_has_pick <= 1'b0;
                if (i_cfg.fit_policy == POL_NEXT && r_rv && (r_ri < r_count)) begin
                    r_idx <= r_ri[IDX_W-1:0];
                end else begin
                    r_idx <= '0;
                end
            end
            OP_SCAN: begin
                if (w_upd) begin
                    r_pick      <= r_idx;
                    r_pick_size <= w_rd_size;
                    r_has_pick  <= 1'b1;
                end
                // the scan wraps round to the start of the table, as next fit needs
                if ((CNT_W'(r_idx) + CNT_W'(1)) == r_count) r_idx <= '0;
                else r_idx <= r_idx + IDX_W'(1);
                r_iter <= r_iter + CNT_W'(1);
            end
            OP_ALLOC: begin
                r_idx        <= '0;
                r_pos        <= '0;
                r_res_off    <= '0;
                r_res_status <= (r_has_pick || w_grow_ok) ? STAT_ALLOC : STAT_NOSPACE;
                if (r_has_pick) begin
                    r_tgt      <= r_pick;
                    r_res_size <= w_split ? w_s : r_pick_size;
                end else if (w_grow_ok) begin
                    r_tgt      <= r_count[IDX_W-1:0];
                    r_res_size <= w_s;
                end else begin
                    r_res_size <= '0;
                end
            end
            OP_POS: begin
                if (r_idx == r_tgt) begin
                    r_res_off <= w_pos_hdr[SIZE_BITS-1:0];
                end else begin
                    r_pos <= w_pos_step;
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            OP_FIND_INIT: begin
                r_idx  <= '0;
                r_iter <= '0;
                r_pos  <= '0;
            end
            OP_FIND: begin
                r_pos  <= w_pos_step;
                r_idx  <= r_idx + IDX_W'(1);
                r_iter <= r_iter + CNT_W'(1);
            end
            OP_FREE_HIT: begin
                r_res_off    <= r_target;
                r_res_size   <= w_rd_size;
                r_res_status <= STAT_FREED;
                r_idx        <= '0;
            end
            OP_MERGE_INIT: begin
                r_acc      <= w_rd_size;
                r_acc_free <= w_rd_free;
                r_m        <= '0;
                r_idx      <= IDX_W'(1);
            end
            OP_MERGE: begin
                // r_idx tracks r_m + 1, the neighbour under test
                if (w_absorb) begin
                    r_acc <= w_merge_sat;
                end else begin
                    r_acc      <= w_rd_size;
                    r_acc_free <= w_rd_free;
                    r_m        <= r_m + IDX_W'(1);
                    r_idx      <= r_idx + IDX_W'(1);
                end
            end
            OP_RES_NULL: begin
                r_res_off    <= '0;
                r_res_size   <= '0;
                r_res_status <= STAT_NULL;
            end
            OP_RES_NOSPACE: begin
                r_res_off    <= '0;
                r_res_size   <= '0;
                r_res_status <= STAT_NOSPACE;
            end
            OP_RES_UNKNOWN: begin
                r_res_off    <= '0;
                r_res_size   <= '0;
                r_res_status <= STAT_UNKNOWN;
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT) begin
            r_out_off    <= r_res_off;
            r_out_size   <= r_res_size;
            r_out_status <= r_res_status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_data_offset  = r_out_off;
    assign o_granted_size = r_out_size;
    assign o_status       = r_out_status;

endmodule
